>>> hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the text console.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with async active-low reset masking.
`define TCW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("text console assertion failed");

// Same-cycle implication.
`define TCW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  `TCW_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

// Next-cycle implication.
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  `TCW_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

>>> hw/rtl/tcw_pkg.sv
// Package for the text console writer: field widths, opcodes,
// register indexes, FSM states and the screen cell layout. No dependencies.
`default_nettype none

package tcw_pkg;

  localparam int unsigned DEF_SCREEN_COLS = 80;
  localparam int unsigned DEF_SCREEN_ROWS = 25;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned COLOR_W  = 4;
  localparam int unsigned POS_W    = 11;  // cursor_position and cell_address ports
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FG = 1'b0,
    CFG_BG = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_ZERO,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [COLOR_W-1:0] bg;
    logic [COLOR_W-1:0] fg;
    logic [CHAR_W-1:0]  ch;
  } cell_t;

endpackage

`default_nettype wire

>>> hw/rtl/text_console_writer.sv
// Text console writer: cell store, cursor and scroll/clear sequencer.
// A put without scroll and the unused opcode report straight from idle, a read cell
// through ST_READ; a put that scrolls sweeps the store (row copy plus bottom-row
// zeroing), clear zeroes every cell; one item at a time, store write port sets the sweeps.
// Reset: a clearing pass over every cell holds busy high.
// Results show for one cycle on done_o; the receiver cannot stall.
`default_nettype none

module text_console_writer #(
  parameter int unsigned SCREEN_COLS = tcw_pkg::DEF_SCREEN_COLS,
  parameter int unsigned SCREEN_ROWS = tcw_pkg::DEF_SCREEN_ROWS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // command channel
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [tcw_pkg::OP_W-1:0]        opcode_i,
  input  wire logic [tcw_pkg::CHAR_W-1:0]      char_code_i,
  input  wire logic [tcw_pkg::POS_W-1:0]       cell_address_i,
  // configuration writes
  input  wire logic                            cfg_we_i,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [tcw_pkg::COLOR_W-1:0]     cfg_data_i,
  // result strobe
  output logic                                 done_o,
  output logic [tcw_pkg::POS_W-1:0]            cursor_position_o,
  output logic                                 scrolled_o,
  output logic [tcw_pkg::CHAR_W-1:0]           cell_char_o,
  output logic [tcw_pkg::COLOR_W-1:0]          cell_fg_o,
  output logic [tcw_pkg::COLOR_W-1:0]          cell_bg_o
);

  import tcw_pkg::*;

  localparam int unsigned NCELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int unsigned AW     = $clog2(NCELLS);
  localparam int unsigned TW     = AW + 1;              // cursor target, may reach NCELLS
  localparam int unsigned CW     = $clog2(SCREEN_COLS);
  localparam int unsigned XW     = ((AW > POS_W) ? AW : POS_W) + 1;

  localparam logic [AW-1:0] LAST_COPY  = AW'(NCELLS - SCREEN_COLS - 1);
  localparam logic [AW-1:0] BOTTOM_ROW = AW'(NCELLS - SCREEN_COLS);
  localparam logic [AW-1:0] LAST_CELL  = AW'(NCELLS - 1);
  localparam logic [AW-1:0] ROW_STEP   = AW'(SCREEN_COLS);
  localparam logic [CW-1:0] LAST_COL   = CW'(SCREEN_COLS - 1);

  // ---------------------------------------------------------------
  // Color registers
  // ---------------------------------------------------------------
  logic [COLOR_W-1:0] fg_q, bg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= 4'd15;
      bg_q <= 4'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FG:  fg_q <= cfg_data_i;
        CFG_BG:  bg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------
  state_e         state_q, state_d;
  logic [AW-1:0]  cursor_q, cursor_d;     // linear cursor
  logic [CW-1:0]  col_q, col_d;           // cursor column, kept beside the linear cursor
  logic [AW-1:0]  cnt_q, cnt_d;           // sweep index for copy / zero passes
  logic           report_q, report_d;     // sweep ends in a result (not the reset pass)
  logic           pend_q, pend_d;         // sweep write queued for next cycle
  logic [AW-1:0]  pend_addr_q, pend_addr_d;
  logic           pend_zero_q, pend_zero_d;
  logic           rd_ok_q, rd_ok_d;       // read address was inside the screen
  logic           done_q, done_d;
  logic           scrolled_q, scrolled_d;
  cell_t          cell_q, cell_d;

  // store ports
  logic           mem_we;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  cell_t          mem_wdata, mem_rdata;

  tcw_store #(
    .DEPTH(NCELLS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------
  // Put datapath: next cursor, newline jump, scroll detect
  // ---------------------------------------------------------------
  logic           is_nl;
  logic [TW-1:0]  target;
  logic           wrap;
  logic [CW-1:0]  col_next;
  logic [XW-1:0]  addr_x;
  logic           in_range;
  cell_t          put_cell;

  always_comb begin
    is_nl  = (char_code_i == NEWLINE_CODE);
    // newline lands on column 0 of the next row: cursor - col + COLS
    target = is_nl ? (TW'(cursor_q) - TW'(col_q) + TW'(SCREEN_COLS))
                   : (TW'(cursor_q) + TW'(1));
    wrap   = (target >= TW'(NCELLS));
    if (is_nl || (col_q == LAST_COL)) begin
      col_next = '0;
    end else begin
      col_next = col_q + CW'(1);
    end
    addr_x   = XW'(cell_address_i);
    in_range = (addr_x < XW'(NCELLS));
    put_cell = '{bg: bg_q, fg: fg_q, ch: char_code_i};
  end

  assign busy = (state_q != ST_IDLE);

  // ---------------------------------------------------------------
  // Next state and store control
  // ---------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    col_d       = col_q;
    cnt_d       = cnt_q;
    report_d    = report_q;
    pend_d      = 1'b0;
    pend_addr_d = cnt_q;
    pend_zero_d = 1'b1;
    rd_ok_d     = rd_ok_q;
    done_d      = 1'b0;
    scrolled_d  = scrolled_q;
    cell_d      = cell_q;
    mem_raddr   = addr_x[AW-1:0];
    // a put overrides a queued sweep write, but puts only write from idle, when nothing is queued
    mem_we      = pend_q;
    mem_waddr   = pend_addr_q;
    mem_wdata   = pend_zero_q ? cell_t'('0) : mem_rdata;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          scrolled_d = 1'b0;
          cell_d     = '0;
          case (opcode_i)
            OP_PUT: begin
              if (!is_nl) begin
                mem_we    = 1'b1;
                mem_waddr = cursor_q;
                mem_wdata = put_cell;
              end
              col_d = col_next;
              if (wrap) begin
                // scroll: cursor drops one row, rows shift up through the store
                cursor_d   = AW'(target - TW'(SCREEN_COLS));
                scrolled_d = 1'b1;
                cnt_d      = '0;
                report_d   = 1'b1;
                state_d    = ST_COPY;
              end else begin
                cursor_d = target[AW-1:0];
                done_d   = 1'b1;
              end
            end
            OP_CLEAR: begin
              cursor_d = '0;
              col_d    = '0;
              cnt_d    = '0;
              report_d = 1'b1;
              state_d  = ST_ZERO;
            end
            OP_READ: begin
              rd_ok_d = in_range;
              state_d = ST_READ;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        cell_d  = rd_ok_q ? mem_rdata : cell_t'('0);
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_COPY: begin
        // read the cell one row down, write it here in the following cycle
        mem_raddr   = cnt_q + ROW_STEP;
        pend_d      = 1'b1;
        pend_zero_d = 1'b0;
        if (cnt_q == LAST_COPY) begin
          cnt_d   = BOTTOM_ROW;
          state_d = ST_ZERO;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      ST_ZERO: begin
        pend_d = 1'b1;
        if (cnt_q == LAST_CELL) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      ST_FIN: begin
        // last queued write drains this cycle
        done_d  = report_q;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Reset enters the zero sweep directly: the clearing pass without a result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_ZERO;
      cursor_q <= '0;
      col_q    <= '0;
      cnt_q    <= '0;
      report_q <= 1'b0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      col_q    <= col_d;
      cnt_q    <= cnt_d;
      report_q <= report_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    pend_zero_q <= pend_zero_d;
    rd_ok_q     <= rd_ok_d;
    scrolled_q  <= scrolled_d;
    cell_q      <= cell_d;
  end

  // ---------------------------------------------------------------
  // Result ports
  // ---------------------------------------------------------------
  logic [XW-1:0] cursor_x;

  assign cursor_x          = XW'(cursor_q);
  assign done_o            = done_q;
  assign cursor_position_o = cursor_x[POS_W-1:0];
  assign scrolled_o        = scrolled_q;
  assign cell_char_o       = cell_q.ch;
  assign cell_fg_o         = cell_q.fg;
  assign cell_bg_o         = cell_q.bg;

endmodule

`default_nettype wire

>>> hw/rtl/tcw_store.sv
// Screen cell memory: one write port, one read port, registered read data.
// Depends on tcw_pkg (cell_t).
`default_nettype none

module tcw_store #(
  parameter int unsigned DEPTH = tcw_pkg::DEF_SCREEN_COLS * tcw_pkg::DEF_SCREEN_ROWS,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  tcw_pkg::cell_t     wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output tcw_pkg::cell_t     rdata_o
);

  tcw_pkg::cell_t mem_q [DEPTH];
  tcw_pkg::cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/tcw_checker.sv
// Port-level checker for the text console writer, bound to the top level.
// Depends on tcw_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module tcw_checker #(
  parameter int unsigned SCREEN_COLS = tcw_pkg::DEF_SCREEN_COLS,
  parameter int unsigned SCREEN_ROWS = tcw_pkg::DEF_SCREEN_ROWS
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic [tcw_pkg::OP_W-1:0]      opcode_i,
  input wire logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input wire logic                          done_o,
  input wire logic [tcw_pkg::POS_W-1:0]     cursor_position_o,
  input wire logic                          scrolled_o
);

  import tcw_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(SCREEN_COLS * SCREEN_ROWS - 1);

  logic acc;
  assign acc = start && !busy;

  // a result always leaves the block ready for the next item
  `TCW_ASSERT_IMPL(a_done_idle, clk_i, rst_ni, done_o, !busy)

  // scrolling results come only out of the store sweep
  `TCW_ASSERT_IMPL(a_scroll_swept, clk_i, rst_ni, done_o && scrolled_o, $past(busy))

  // a plain character away from the last cell reports next cycle, cursor + 1
  `TCW_ASSERT_NEXT(a_put_step, clk_i, rst_ni, acc && (opcode_i == OP_PUT) && (char_code_i != NEWLINE_CODE) && (cursor_position_o != LAST_POS), done_o && !scrolled_o && (cursor_position_o == POS_W'($past(cursor_position_o) + 1'b1)))

  // a read reports after the store read and ST_READ, and leaves the cursor alone
  `TCW_ASSERT_IMPL(a_read_lat, clk_i, rst_ni, acc && (opcode_i == OP_READ), ##2 (done_o && !scrolled_o && (cursor_position_o == $past(cursor_position_o, 2))))

endmodule

bind text_console_writer tcw_checker #(
  .SCREEN_COLS(SCREEN_COLS),
  .SCREEN_ROWS(SCREEN_ROWS)
) u_tcw_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .opcode_i          (opcode_i),
  .char_code_i       (char_code_i),
  .done_o            (done_o),
  .cursor_position_o (cursor_position_o),
  .scrolled_o        (scrolled_o)
);

`default_nettype wire

>>> test/text_console_writer_tb.sv
// Testbench for text_console_writer: drives console commands and color writes,
// predicts each result from its own screen model and checks it field by field.
// Depends on tcw_pkg and the text_console_writer RTL only.
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int unsigned COLS         = DEF_SCREEN_COLS;
  localparam int unsigned ROWS         = DEF_SCREEN_ROWS;
  localparam int unsigned CELLS        = COLS * ROWS;
  // scroll, clear and the reset clearing pass each take one sweep of the store
  localparam int unsigned SWEEP_CYCLES = CELLS + 1;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam int unsigned MAX_PRINTS   = 30;

  typedef struct packed {
    logic [POS_W-1:0] cursor;
    logic             scrolled;
    cell_t            cell_val;
  } console_result_t;

  // Screen model plus the queue of results still owed by the block.
  class console_checker;
    cell_t              screen [CELLS];
    int unsigned        cursor;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
    console_result_t    owed_q [$];
    int unsigned        errors;
    int unsigned        n_items, n_results, n_scrolls, n_reads, n_clears;

    function new();
      foreach (screen[i]) screen[i] = '0;
      cursor   = 0;
      fg_color = 4'd15;
      bg_color = 4'd0;
    endfunction

    function void report_mismatch(string msg);
      if (errors < MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endfunction

    function void set_color(cfg_idx_e idx, logic [COLOR_W-1:0] value);
      if (idx == CFG_FG) fg_color = value;
      else bg_color = value;
    endfunction

    // Move the cursor; running off the last cell shifts every row up by one.
    function bit move_cursor(int unsigned target);
      if (target >= CELLS) begin
        for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
        for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = '0;
        cursor = target - COLS;
        return 1'b1;
      end
      cursor = target;
      return 1'b0;
    endfunction

    function void note_command(op_e op, logic [CHAR_W-1:0] ch, logic [POS_W-1:0] addr);
      console_result_t r;
      r = '0;
      n_items++;
      case (op)
        OP_PUT: begin
          if (ch == NEWLINE_CODE) begin
            r.scrolled = move_cursor(cursor + COLS - cursor % COLS);
          end else begin
            screen[cursor] = '{bg: bg_color, fg: fg_color, ch: ch};
            r.scrolled = move_cursor(cursor + 1);
          end
          if (r.scrolled) n_scrolls++;
        end
        OP_CLEAR: begin
          foreach (screen[i]) screen[i] = '0;
          cursor = 0;
          n_clears++;
        end
        OP_READ: begin
          n_reads++;
          if (addr < CELLS) r.cell_val = screen[addr];
        end
        default: ;
      endcase
      r.cursor = cursor[POS_W-1:0];
      owed_q.push_back(r);
    endfunction

    function void check_result(console_result_t got);
      console_result_t want;
      n_results++;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing owed", n_results));
        return;
      end
      want = owed_q.pop_front();
      if (got.cursor !== want.cursor)
        report_mismatch($sformatf("result %0d cursor %0d, expected %0d",
                                  n_results, got.cursor, want.cursor));
      if (got.scrolled !== want.scrolled)
        report_mismatch($sformatf("result %0d scrolled %0b, expected %0b",
                                  n_results, got.scrolled, want.scrolled));
      if (got.cell_val.ch !== want.cell_val.ch)
        report_mismatch($sformatf("result %0d char %02h, expected %02h",
                                  n_results, got.cell_val.ch, want.cell_val.ch));
      if (got.cell_val.fg !== want.cell_val.fg)
        report_mismatch($sformatf("result %0d fg %0d, expected %0d",
                                  n_results, got.cell_val.fg, want.cell_val.fg));
      if (got.cell_val.bg !== want.cell_val.bg)
        report_mismatch($sformatf("result %0d bg %0d, expected %0d",
                                  n_results, got.cell_val.bg, want.cell_val.bg));
    endfunction

    function void flush_leftovers();
      while (owed_q.size() != 0) begin
        void'(owed_q.pop_front());
        report_mismatch("expected result never arrived");
      end
    endfunction
  endclass

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 start          = 1'b0;
  logic                 busy;
  logic [OP_W-1:0]      opcode_i       = '0;
  logic [CHAR_W-1:0]    char_code_i    = '0;
  logic [POS_W-1:0]     cell_address_i = '0;
  logic                 cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i      = '0;
  logic [COLOR_W-1:0]   cfg_data_i     = '0;
  logic                 done_o;
  logic [POS_W-1:0]     cursor_position_o;
  logic                 scrolled_o;
  logic [CHAR_W-1:0]    cell_char_o;
  logic [COLOR_W-1:0]   cell_fg_o;
  logic [COLOR_W-1:0]   cell_bg_o;

  console_checker  console_chk = new();
  console_result_t seen;
  int unsigned     no_idle_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  text_console_writer u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .opcode_i          (opcode_i),
    .char_code_i       (char_code_i),
    .cell_address_i    (cell_address_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .done_o            (done_o),
    .cursor_position_o (cursor_position_o),
    .scrolled_o        (scrolled_o),
    .cell_char_o       (cell_char_o),
    .cell_fg_o         (cell_fg_o),
    .cell_bg_o         (cell_bg_o)
  );

  // Results live for one cycle only; take them at the edge that closes it.
  // Outputs read here still hold their pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      seen.cursor      = cursor_position_o;
      seen.scrolled    = scrolled_o;
      seen.cell_val.ch = cell_char_o;
      seen.cell_val.fg = cell_fg_o;
      seen.cell_val.bg = cell_bg_o;
      console_chk.check_result(seen);
    end
  end

  // Hold start low until the block is idle and owes nothing.
  task automatic settle_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (console_chk.owed_q.size() != 0 || busy !== 1'b0);
  endtask

  // Both color registers back to back; write enable stays high across them.
  task automatic set_colors(logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_FG;
    cfg_data_i <= fg;
    @(posedge clk_i);
    console_chk.set_color(CFG_FG, fg);
    cfg_idx_i  <= CFG_BG;
    cfg_data_i <= bg;
    @(posedge clk_i);
    console_chk.set_color(CFG_BG, bg);
    cfg_we_i   <= 1'b0;
  endtask

  // One console command. Start stays high between items when there is no gap,
  // so it only ever gets one assignment per time step.
  task automatic send_command(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                              logic [POS_W-1:0] addr);
    int unsigned gap;
    if (no_idle_left != 0) begin
      gap = 0;
      no_idle_left--;
    end else if ($urandom_range(0, 29) == 0) begin
      gap = 0;
      no_idle_left = $urandom_range(20, 60);
    end else begin
      gap = $urandom_range(0, 19);
    end
    // now and then let the block run dry before the next item
    if ($urandom_range(0, 39) == 0) begin
      start <= 1'b0;
      do @(posedge clk_i); while (console_chk.owed_q.size() != 0);
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    opcode_i       <= op;
    char_code_i    <= ch;
    cell_address_i <= addr;
    do @(posedge clk_i); while (busy !== 1'b0);
    console_chk.note_command(op_e'(op), ch, addr);
  endtask

  // Printable-ish text byte; any value but newline.
  function automatic logic [CHAR_W-1:0] text_byte();
    logic [CHAR_W-1:0] b;
    b = CHAR_W'($urandom_range(0, 255));
    if (b == NEWLINE_CODE) b = 8'hF5;
    return b;
  endfunction

  // Reads mostly land just behind the cursor where text was written.
  function automatic logic [POS_W-1:0] read_address();
    int a;
    if ($urandom_range(0, 9) < 7) begin
      a = int'(console_chk.cursor) - int'($urandom_range(0, 2 * COLS));
      if (a < 0) a = 0;
      return POS_W'(a);
    end
    return POS_W'($urandom_range(0, 2047));
  endfunction

  initial begin
    int unsigned       sent;
    int unsigned       line_len;
    int unsigned       pick;
    logic [COLOR_W-1:0] fg_set [6];
    logic [COLOR_W-1:0] bg_set [6];

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle_idle();  // rides out the clearing pass after reset
    set_colors(4'd9, 4'd6);

    // Directed: byte extremes, newline from mid-row and row start,
    // range edges of reads, the unused opcode and a clear.
    send_command(OP_READ, 8'h00, 11'd0);
    send_command(OP_PUT, 8'h00, 11'd0);
    send_command(OP_PUT, 8'hFF, 11'h7FF);
    send_command(OP_PUT, 8'h41, 11'd0);
    send_command(OP_PUT, NEWLINE_CODE, 11'd0);
    send_command(OP_PUT, NEWLINE_CODE, 11'd0);
    send_command(OP_READ, 8'h00, 11'd0);
    send_command(OP_READ, 8'hFF, 11'd1);
    send_command(OP_READ, 8'h00, 11'd2);
    send_command(OP_READ, 8'h00, 11'd1999);
    send_command(OP_READ, 8'h00, 11'd2000);
    send_command(OP_READ, 8'h00, 11'h7FF);
    send_command(OP_NOP, 8'hFF, 11'h7FF);
    send_command(OP_PUT, 8'hF5, 11'h555);
    send_command(OP_READ, 8'h00, 11'd160);
    send_command(OP_CLEAR, 8'h00, 11'd0);
    send_command(OP_READ, 8'h00, 11'd0);
    send_command(OP_READ, 8'h00, 11'd1);
    send_command(OP_PUT, NEWLINE_CODE, 11'd0);
    send_command(OP_NOP, 8'h00, 11'd0);

    // Random phases, each under its own color setting; extremes first.
    fg_set = '{4'd0, 4'd15, 4'd0, 4'd15, 4'd0, 4'd0};
    bg_set = '{4'd15, 4'd0, 4'd0, 4'd15, 4'd0, 4'd0};
    fg_set[4] = COLOR_W'($urandom_range(0, 15));
    bg_set[4] = COLOR_W'($urandom_range(0, 15));
    fg_set[5] = COLOR_W'($urandom_range(0, 15));
    bg_set[5] = COLOR_W'($urandom_range(0, 15));
    for (int ph = 0; ph < 6; ph++) begin
      settle_idle();
      set_colors(fg_set[ph], bg_set[ph]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          send_command(OP_CLEAR, CHAR_W'($urandom), POS_W'($urandom));
          sent++;
        end else if (pick < 5) begin
          // noise: unused opcode or a lone raw byte
          if (pick == 2) send_command(OP_NOP, CHAR_W'($urandom), POS_W'($urandom));
          else send_command(OP_PUT, CHAR_W'($urandom), POS_W'($urandom));
          sent++;
        end else if (pick < 20) begin
          send_command(OP_READ, CHAR_W'($urandom), read_address());
          sent++;
        end else begin
          // a line of text: mostly short so rows fill and the screen scrolls,
          // sometimes long enough to wrap past the last cell
          if ($urandom_range(0, 99) < 85) line_len = $urandom_range(0, 12);
          else line_len = $urandom_range(60, 170);
          for (int k = 0; k < line_len; k++) begin
            send_command(OP_PUT, text_byte(), POS_W'($urandom));
            sent++;
          end
          send_command(OP_PUT, NEWLINE_CODE, POS_W'($urandom));
          sent++;
        end
      end
    end

    start <= 1'b0;
    for (int n = 0; n < 4 * SWEEP_CYCLES && console_chk.owed_q.size() != 0; n++)
      @(posedge clk_i);
    repeat (SWEEP_CYCLES + 10) @(posedge clk_i);
    console_chk.flush_leftovers();

    $display("Covered %0d commands (%0d reads, %0d clears, %0d scrolls) and %0d results",
             console_chk.n_items, console_chk.n_reads, console_chk.n_clears,
             console_chk.n_scrolls, console_chk.n_results);
    $display("under six color settings; %0d mismatches", console_chk.errors);
    if (console_chk.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Slowest correct run: reset pass plus at most ~1650 items, each a full sweep
  // with the longest gap; allow several times that.
  initial begin
    #150000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
